>>> src/text_lcd_cursor_controller_unit_defines.svh
// Assertion macros shared by the cursor controller RTL.
`ifndef TEXT_LCD_CURSOR_CONTROLLER_UNIT_DEFINES_SVH
`define TEXT_LCD_CURSOR_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on clock, idle during reset.
`define TLCD_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tlcd same-cycle check failed");

// Next-cycle implication, checked on clock, idle during reset.
`define TLCD_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tlcd next-cycle check failed");

`else

`define TLCD_ASSERT_SAME(label, pre, post)
`define TLCD_ASSERT_NEXT(label, pre, post)

`endif

`endif

>>> src/tlcd_pkg.sv
// Types, constants and helpers for the text LCD cursor controller.
package tlcd_pkg;

   localparam int NumSlots = 3;

   localparam logic [7:0] CHAR_RETURN    = 8'd13;
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;

   localparam logic [7:0] CMD_SET_ADDR = 8'h80;
   localparam logic [7:0] CMD_CLEAR    = 8'h01;

   localparam logic [4:0] NUM_COLS = 5'd20;
   localparam logic [4:0] LAST_COL = 5'd19;

   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   typedef logic [1:0] row_type;
   typedef logic [4:0] col_type;

   typedef struct packed {
      row_type row;
      col_type col;
   } cursor_type;

   typedef struct packed {
      logic       register_select;
      logic [7:0] bus_byte;
      logic       needs_long_wait;
      logic       last;
   } entry_type;

   // All bus writes caused by one character, slot 0 goes out first.
   typedef struct packed {
      logic [NumSlots-1:0]      valid;
      entry_type [NumSlots-1:0] entry;
   } burst_type;

   function automatic logic [7:0] row_base(input row_type row);
      logic [7:0] base;
      unique case (row)
         2'd0: base = 8'h00;
         2'd1: base = 8'h40;
         2'd2: base = 8'h14;
         2'd3: base = 8'h54;
         default: base = 8'h00;
      endcase
      return base;
   endfunction

   function automatic logic [7:0] set_addr(input cursor_type cur);
      return CMD_SET_ADDR + row_base(cur.row) + {3'b000, cur.col};
   endfunction

endpackage

>>> src/text_lcd_cursor_controller_unit.sv
// Top level of the text LCD cursor controller.
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_character
//   rsp     | out       | rsp_valid, rsp_ready, rsp_register_select, rsp_bus_byte,
//           |           | rsp_needs_long_wait, rsp_last
// A character is decoded in the cycle it is accepted; its one to three bus
// writes are loaded into a three-slot shift register and leave one per cycle while rsp_ready is high.
// The next character is taken in the same cycle the final write transfers.
// Reset clears the cursor to row 0, column 0 and empties the slots.
`include "text_lcd_cursor_controller_unit_defines.svh"

module text_lcd_cursor_controller_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_character,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_register_select,
   output logic [7:0] rsp_bus_byte,
   output logic       rsp_needs_long_wait,
   output logic       rsp_last
);

   tlcd_pkg::cursor_type cursor_ff;
   tlcd_pkg::cursor_type cursor_in;
   tlcd_pkg::cursor_type cursor_next;
   tlcd_pkg::burst_type  burst;

   logic [tlcd_pkg::NumSlots-1:0]      slot_valid_ff;
   logic [tlcd_pkg::NumSlots-1:0]      slot_valid_in;
   tlcd_pkg::entry_type [tlcd_pkg::NumSlots-1:0] slot_ff;
   tlcd_pkg::entry_type [tlcd_pkg::NumSlots-1:0] slot_in;

   logic req_fire;
   logic rsp_fire;

   tlcd_decode u_decode (
      .character   (req_character),
      .cursor      (cursor_ff),
      .next_cursor (cursor_next),
      .burst       (burst)
   );

   assign rsp_valid = slot_valid_ff[0];
   assign rsp_fire  = rsp_valid && rsp_ready;
   // take a new character when empty or when the final write transfers now
   assign req_ready = !slot_valid_ff[0] || (rsp_fire && !slot_valid_ff[1]);
   assign req_fire  = req_valid && req_ready;

   assign rsp_register_select = slot_ff[0].register_select;
   assign rsp_bus_byte        = slot_ff[0].bus_byte;
   assign rsp_needs_long_wait = slot_ff[0].needs_long_wait;
   assign rsp_last            = slot_ff[0].last;

   always_comb begin
      cursor_in     = cursor_ff;
      slot_valid_in = slot_valid_ff;
      slot_in       = slot_ff;
      if (req_fire) begin
         cursor_in     = cursor_next;
         slot_valid_in = burst.valid;
         slot_in       = burst.entry;
      end else if (rsp_fire) begin
         // advance the queue by one slot
         slot_valid_in = {1'b0, slot_valid_ff[tlcd_pkg::NumSlots-1:1]};
         slot_in       = {slot_ff[tlcd_pkg::NumSlots-1], slot_ff[tlcd_pkg::NumSlots-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff     <= '0;
         slot_valid_ff <= '0;
      end else begin
         cursor_ff     <= cursor_in;
         slot_valid_ff <= slot_valid_in;
      end
      slot_ff <= slot_in;
   end

   `TLCD_ASSERT_SAME(a_last_ends_burst, rsp_valid && rsp_last, !slot_valid_ff[1])
   `TLCD_ASSERT_SAME(a_slots_packed, slot_valid_ff[2], slot_valid_ff[1])
   `TLCD_ASSERT_SAME(a_column_in_range, 1'b1, cursor_ff.col < tlcd_pkg::NUM_COLS)
   `TLCD_ASSERT_NEXT(a_accept_gives_output, req_fire, rsp_valid)
   `TLCD_ASSERT_SAME(a_long_wait_is_clear, rsp_valid && rsp_needs_long_wait,
      rsp_register_select == tlcd_pkg::RS_COMMAND && rsp_bus_byte == tlcd_pkg::CMD_CLEAR)

endmodule

>>> src/tlcd_decode.sv
// Per-character decode: next cursor position and the burst of bus writes.
module tlcd_decode (
   input  logic [7:0]          character,
   input  tlcd_pkg::cursor_type cursor,
   output tlcd_pkg::cursor_type next_cursor,
   output tlcd_pkg::burst_type  burst
);

   logic                 is_move;
   logic                 at_home;
   tlcd_pkg::entry_type  addr_entry;
   tlcd_pkg::entry_type  data_entry;
   tlcd_pkg::entry_type  clear_entry;

   always_comb begin
      next_cursor = cursor;
      is_move     = 1'b1;
      unique case (character)
         tlcd_pkg::CHAR_RETURN: begin
            next_cursor.col = '0;
         end
         tlcd_pkg::CHAR_NEWLINE: begin
            next_cursor.row = cursor.row + 2'd1;
            next_cursor.col = (cursor.col >= tlcd_pkg::NUM_COLS) ? '0 : cursor.col;
         end
         tlcd_pkg::CHAR_BACKSPACE: begin
            // stop at column 0; an out-of-range column overflows instead
            if (cursor.col >= tlcd_pkg::NUM_COLS) begin
               next_cursor.row = cursor.row + 2'd1;
               next_cursor.col = '0;
            end else if (cursor.col != '0) begin
               next_cursor.col = cursor.col - 5'd1;
            end
         end
         default: begin
            is_move = 1'b0;
            if (cursor.col >= tlcd_pkg::LAST_COL) begin
               next_cursor.row = cursor.row + 2'd1;
               next_cursor.col = '0;
            end else begin
               next_cursor.col = cursor.col + 5'd1;
            end
         end
      endcase
   end

   assign at_home = (cursor.row == '0) && (cursor.col == '0);

   assign addr_entry  = '{register_select: tlcd_pkg::RS_COMMAND,
                          bus_byte: tlcd_pkg::set_addr(next_cursor),
                          needs_long_wait: 1'b0, last: 1'b1};
   assign data_entry  = '{register_select: tlcd_pkg::RS_DATA, bus_byte: character,
                          needs_long_wait: 1'b0, last: 1'b0};
   assign clear_entry = '{register_select: tlcd_pkg::RS_COMMAND,
                          bus_byte: tlcd_pkg::CMD_CLEAR,
                          needs_long_wait: 1'b1, last: 1'b0};

   always_comb begin
      burst = '0;
      if (is_move) begin
         burst.valid    = 3'b001;
         burst.entry[0] = addr_entry;
      end else if (at_home) begin
         burst.valid    = 3'b111;
         burst.entry[0] = clear_entry;
         burst.entry[1] = data_entry;
         burst.entry[2] = addr_entry;
      end else begin
         burst.valid    = 3'b011;
         burst.entry[0] = data_entry;
         burst.entry[1] = addr_entry;
      end
   end

endmodule

>>> verif/tb_text_lcd_cursor_controller_unit.sv
// Testbench for the text LCD cursor controller: directed and random character streams.
module tb_text_lcd_cursor_controller_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 8;
   // DDRAM offset of each display line, line 0 in the low byte
   localparam logic [31:0] LINE_OFFSETS = {8'h54, 8'h14, 8'h40, 8'h00};

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_character;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_register_select;
   logic [7:0] rsp_bus_byte;
   logic       rsp_needs_long_wait;
   logic       rsp_last;

   // Cursor as the display should see it after every accepted character
   tlcd_pkg::row_type   line_now;
   tlcd_pkg::col_type   column_now;
   tlcd_pkg::entry_type pending_writes[$];

   int send_idle_pct;
   int recv_idle_pct;
   int error_count = 0;
   int chars_sent;
   int writes_checked = 0;
   int clears_checked = 0;
   int cycle_count = 0;

   text_lcd_cursor_controller_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_character       (req_character),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_register_select (rsp_register_select),
      .rsp_bus_byte        (rsp_bus_byte),
      .rsp_needs_long_wait (rsp_needs_long_wait),
      .rsp_last            (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      error_count++;
      $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   function automatic void push_write(input logic rs, input logic [7:0] bus_value,
                                      input logic long_wait, input logic is_last);
      tlcd_pkg::entry_type w;
      w.register_select = rs;
      w.bus_byte        = bus_value;
      w.needs_long_wait = long_wait;
      w.last            = is_last;
      pending_writes.push_back(w);
   endfunction

   // Work out the bus writes for one character and move the cursor.
   function automatic void predict_writes(input logic [7:0] ch);
      tlcd_pkg::row_type next_line;
      tlcd_pkg::col_type next_column;
      next_line   = line_now;
      next_column = column_now;
      case (ch)
         tlcd_pkg::CHAR_RETURN: next_column = '0;
         tlcd_pkg::CHAR_NEWLINE: next_line = line_now + 2'd1;
         tlcd_pkg::CHAR_BACKSPACE: begin
            if (column_now != '0) next_column = column_now - 5'd1;
         end
         default: begin
            if (line_now == '0 && column_now == '0)
               push_write(tlcd_pkg::RS_COMMAND, tlcd_pkg::CMD_CLEAR, 1'b1, 1'b0);
            push_write(tlcd_pkg::RS_DATA, ch, 1'b0, 1'b0);
            // step past the last column into the next line, line 3 back to 0
            if (column_now == tlcd_pkg::LAST_COL) begin
               next_column = '0;
               next_line   = line_now + 2'd1;
            end else begin
               next_column = column_now + 5'd1;
            end
         end
      endcase
      line_now   = next_line;
      column_now = next_column;
      push_write(tlcd_pkg::RS_COMMAND,
                 tlcd_pkg::CMD_SET_ADDR + LINE_OFFSETS[line_now*8 +: 8] + {3'b000, column_now},
                 1'b0, 1'b1);
   endfunction

   function automatic logic [7:0] printable_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == tlcd_pkg::CHAR_RETURN || b == tlcd_pkg::CHAR_NEWLINE ||
             b == tlcd_pkg::CHAR_BACKSPACE);
      return b;
   endfunction

   // Offer one character and hold it until the transfer.
   task automatic send_char(input logic [7:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= ch;
      predict_writes(ch);
      chars_sent++;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // Result side: random ready, compare every transfer with the oldest expectation.
   always @(posedge clock) begin
      tlcd_pkg::entry_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_writes.size() == 0) begin
               flag_mismatch($sformatf("unexpected write rs=%0b byte=%02h wait=%0b last=%0b",
                                       rsp_register_select, rsp_bus_byte,
                                       rsp_needs_long_wait, rsp_last));
            end else begin
               want = pending_writes.pop_front();
               writes_checked++;
               if (want.needs_long_wait) clears_checked++;
               if (rsp_register_select !== want.register_select)
                  flag_mismatch($sformatf("register_select got %0b want %0b",
                                          rsp_register_select, want.register_select));
               if (rsp_bus_byte !== want.bus_byte)
                  flag_mismatch($sformatf("bus_byte got %02h want %02h",
                                          rsp_bus_byte, want.bus_byte));
               if (rsp_needs_long_wait !== want.needs_long_wait)
                  flag_mismatch($sformatf("needs_long_wait got %0b want %0b",
                                          rsp_needs_long_wait, want.needs_long_wait));
               if (rsp_last !== want.last)
                  flag_mismatch($sformatf("last got %0b want %0b", rsp_last, want.last));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Printing from home gets a clear first; extremes of the character range.
   task automatic test_home_clear();
      send_char(8'h41);
      send_char(8'h00);
      send_char(8'hFF);
      send_char(8'h80);
      send_char(8'h7F);
      send_char(8'h01);
   endtask

   // Return, line feed with line wrap, and backspace clamped at column 0.
   task automatic test_cursor_moves();
      send_char(tlcd_pkg::CHAR_RETURN);
      send_char(tlcd_pkg::CHAR_BACKSPACE);
      send_char(8'h55);
      send_char(8'h2A);
      send_char(tlcd_pkg::CHAR_BACKSPACE);
      send_char(tlcd_pkg::CHAR_NEWLINE);
      send_char(tlcd_pkg::CHAR_NEWLINE);
      send_char(tlcd_pkg::CHAR_NEWLINE);
      send_char(tlcd_pkg::CHAR_BACKSPACE);
      send_char(tlcd_pkg::CHAR_BACKSPACE);
      send_char(tlcd_pkg::CHAR_NEWLINE);
      send_char(tlcd_pkg::CHAR_RETURN);
      send_char(8'hAA);
      send_char(tlcd_pkg::CHAR_NEWLINE);
      send_char(tlcd_pkg::CHAR_RETURN);
   endtask

   // Mostly lines of random text ended by cursor moves, some raw noise.
   task automatic test_random_text(input int n_chars);
      int target;
      target = chars_sent + n_chars;
      while (chars_sent < target) begin
         if ($urandom_range(99) < 70) begin
            repeat ($urandom_range(1, 24)) send_char(printable_byte());
            case ($urandom_range(3))
               0: begin
                  send_char(tlcd_pkg::CHAR_RETURN);
                  send_char(tlcd_pkg::CHAR_NEWLINE);
               end
               1: send_char(tlcd_pkg::CHAR_NEWLINE);
               2: repeat ($urandom_range(1, 3)) send_char(tlcd_pkg::CHAR_BACKSPACE);
               default: send_char(tlcd_pkg::CHAR_RETURN);
            endcase
         end else begin
            repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(255)));
         end
      end
   endtask

   // Fill the whole screen so every line overflows and line 3 wraps to home.
   task automatic test_screen_wrap();
      send_char(tlcd_pkg::CHAR_RETURN);
      while (line_now != '0) send_char(tlcd_pkg::CHAR_NEWLINE);
      repeat (81) send_char(printable_byte());
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_character = 8'h00;
      line_now      = '0;
      column_now    = '0;
      chars_sent    = 0;
      send_idle_pct = 35;
      recv_idle_pct = 67;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_home_clear();
      test_cursor_moves();
      test_random_text(130);

      send_idle_pct = 67;
      recv_idle_pct = 35;
      test_random_text(130);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_screen_wrap();
      test_random_text(110);

      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d characters, checked %0d bus writes (%0d clears).",
               chars_sent, writes_checked, clears_checked);
      $display("Covered home clears, returns, line feeds, backspaces and screen wrap.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/tlcd_pkg.sv
src/tlcd_decode.sv
src/text_lcd_cursor_controller_unit.sv
verif/tb_text_lcd_cursor_controller_unit.sv
